// ----- design/tcce_pkg.sv -----
// Shared types and constants for the text console cell engine.
`timescale 1ns / 1ps
package tcce_pkg;

  // Byte and glyph codes
  localparam logic [7:0] BLANK_GLYPH  = 8'h20;
  localparam logic [7:0] DASH_GLYPH   = 8'hC4;
  localparam logic [7:0] HYPHEN_GLYPH = 8'h2D;
  localparam logic [7:0] BYTE_LF      = 8'h0A;
  localparam logic [7:0] BYTE_CR      = 8'h0D;
  localparam logic [7:0] BYTE_BS      = 8'h08;
  localparam logic [7:0] BYTE_TAB     = 8'h09;
  localparam logic [7:0] LEAD2_MIN    = 8'hC0;
  localparam logic [7:0] LEAD3_MIN    = 8'hE0;
  localparam logic [7:0] LEAD4_MIN    = 8'hF0;
  localparam logic [7:0] CONT_MIN     = 8'h80;
  localparam logic [20:0] CP_EN_DASH  = 21'h2013;
  localparam logic [20:0] CP_EM_DASH  = 21'h2014;
  localparam logic [20:0] CP_BAR      = 21'h2015;

  // Register indexes
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  // Event kinds
  localparam logic [1:0] EV_WRITE  = 2'd0;
  localparam logic [1:0] EV_SCROLL = 2'd1;
  localparam logic [1:0] EV_READ   = 2'd2;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    CMD_PUT,
    CMD_TAB,
    CMD_NL,
    CMD_CR,
    CMD_BS,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] glyph;
    logic [6:0] rd_col;
    logic [5:0] rd_row;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_EXEC,
    B_RDWAIT,
    B_EMIT,
    B_SCOPY,
    B_SDRAIN,
    B_SBLANK
  } back_state_t;

endpackage

// ----- design/tcce_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module tcce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- design/tcce_queue.sv -----
// Short command queue between the byte decoder and the grid executor.
`timescale 1ns / 1ps
module tcce_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  tcce_pkg::cmd_t         push_cmd,
  input  logic                   pop,
  output tcce_pkg::cmd_t         head_cmd,
  output tcce_pkg::queue_status_t status
);
  import tcce_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r;

  assign head_cmd     = slot_r[rd_ptr_r];
  assign status.full  = (count_r == (PW+1)'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + PW'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + PW'(1);
      if (push && !pop)      count_r <= count_r + (PW+1)'(1);
      else if (pop && !push) count_r <= count_r - (PW+1)'(1);
    end
  end
endmodule

// ----- design/tcce_front.sv -----
// Front end: accepts requests, decodes UTF-8 and classifies into commands.
`timescale 1ns / 1ps
module tcce_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_mode,
  input  logic [7:0]              in_text_byte,
  input  logic [6:0]              in_read_column,
  input  logic [5:0]              in_read_row,
  input  logic                    accept_en,
  input  tcce_pkg::queue_status_t q_status,
  output logic                    push,
  output tcce_pkg::cmd_t          push_cmd
);
  import tcce_pkg::*;

  logic [1:0]  pend_r, pend_nxt;
  logic [20:0] part_r, part_nxt;
  logic        want_push;
  logic        take;
  logic [20:0] part_cont;

  assign in_ready  = accept_en && !q_status.full;
  assign take      = in_valid && in_ready;
  assign push      = take && want_push;
  assign part_cont = {part_r[14:0], in_text_byte[5:0]};

  // classify the byte
  always_comb begin
    pend_nxt        = pend_r;
    part_nxt        = part_r;
    want_push       = 1'b0;
    push_cmd.kind   = CMD_PUT;
    push_cmd.glyph  = in_text_byte;
    push_cmd.rd_col = in_read_column;
    push_cmd.rd_row = in_read_row;
    if (in_mode) begin
      push_cmd.kind = CMD_READ;
      want_push     = 1'b1;
    end else if (in_text_byte >= LEAD4_MIN) begin
      pend_nxt = 2'd3;
      part_nxt = {18'd0, in_text_byte[2:0]};
    end else if (in_text_byte >= LEAD3_MIN) begin
      pend_nxt = 2'd2;
      part_nxt = {17'd0, in_text_byte[3:0]};
    end else if (in_text_byte >= LEAD2_MIN) begin
      pend_nxt = 2'd1;
      part_nxt = {16'd0, in_text_byte[4:0]};
    end else if (in_text_byte >= CONT_MIN) begin
      if (pend_r != 2'd0) begin
        part_nxt = part_cont;
        pend_nxt = pend_r - 2'd1;
        if (pend_r == 2'd1) begin
          want_push = 1'b1;
          push_cmd.glyph = (part_cont == CP_EN_DASH || part_cont == CP_EM_DASH ||
                            part_cont == CP_BAR) ? DASH_GLYPH : HYPHEN_GLYPH;
        end
      end
    end else begin
      want_push = 1'b1;
      case (in_text_byte)
        BYTE_LF:  push_cmd.kind = CMD_NL;
        BYTE_CR:  push_cmd.kind = CMD_CR;
        BYTE_BS:  push_cmd.kind = CMD_BS;
        BYTE_TAB: push_cmd.kind = CMD_TAB;
        default:  push_cmd.kind = CMD_PUT;
      endcase
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      part_r <= '0;
    end else if (take) begin
      pend_r <= pend_nxt;
      part_r <= part_nxt;
    end
  end
endmodule

// ----- design/tcce_back.sv -----
// Back end: owns cursor, grid memory, scroll sequencing and the result register.
`timescale 1ns / 1ps
module tcce_back #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 64,
  parameter int TAB_WIDTH   = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [7:0]              cfg_data,
  input  tcce_pkg::cmd_t          head_cmd,
  input  tcce_pkg::queue_status_t q_status,
  output logic                    pop,
  output logic                    accept_en,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_event_kind,
  output logic [6:0]              out_cell_column,
  output logic [5:0]              out_cell_row,
  output logic [7:0]              out_glyph_code,
  output logic [6:0]              out_scrolled_rows,
  output logic [6:0]              out_cursor_column,
  output logic [5:0]              out_cursor_row,
  output logic                    out_last_event
);
  import tcce_pkg::*;

  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CEW   = $clog2(MAX_COLUMNS + 1);
  localparam int REW   = $clog2(MAX_ROWS + 1);
  localparam int AW    = RW + CW;
  localparam int DEPTH = MAX_ROWS << CW;
  localparam int RECIP = (65536 + TAB_WIDTH - 1) / TAB_WIDTH;
  localparam int PRW   = CEW + 17;
  localparam int QMW   = CEW + 6;

  back_state_t    state_r, state_nxt;
  cmd_t           cmd_r, cmd_nxt;
  logic [CW-1:0]  col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [CEW-1:0] cols_eff_r, cols_eff_nxt;
  logic [REW-1:0] rows_eff_r, rows_eff_nxt;
  logic [REW-1:0] step_r, step_nxt;
  logic [RW-1:0]  cp_row_r, cp_row_nxt;
  logic [CW-1:0]  cp_col_r, cp_col_nxt;
  logic           wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]  wr_addr_r, wr_addr_nxt;
  logic [AW-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic           oob_r, oob_nxt;
  logic           sc_pend_r, sc_pend_nxt;
  logic           copy_pend_r, copy_pend_nxt;
  logic           tab_more_r, tab_more_nxt;

  // pending event
  logic [1:0]     ev_kind_r, ev_kind_nxt;
  logic [6:0]     ev_col_r, ev_col_nxt;
  logic [5:0]     ev_row_r, ev_row_nxt;
  logic [7:0]     ev_glyph_r, ev_glyph_nxt;
  logic [6:0]     ev_scr_r, ev_scr_nxt;
  logic [6:0]     ev_ccol_r, ev_ccol_nxt;
  logic [5:0]     ev_crow_r, ev_crow_nxt;
  logic           ev_last_r, ev_last_nxt;

  // result register
  logic           out_valid_r;
  logic [1:0]     out_kind_r;
  logic [6:0]     out_col_r, out_scr_r, out_ccol_r;
  logic [5:0]     out_row_r, out_crow_r;
  logic [7:0]     out_glyph_r;
  logic           out_last_r;
  logic           can_emit, load_out;

  // memory controls
  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [7:0]     ram_wdata, ram_rdata;

  // cursor arithmetic
  logic [CEW-1:0] newcol;
  logic [REW-1:0] nrow, step_c, n_copy, src_row;
  logic           wrap, scr;
  logic [RW-1:0]  row_after;
  logic [PRW-1:0] prod;
  logic [QMW-1:0] quot;
  logic           tab_stop;
  logic           copy_last_col, copy_last, blank_last;
  logic [31:0]    rd_col_w, rd_row_w;
  logic           rd_in_range;
  logic [CEW-1:0] cfg_cols;
  logic [REW-1:0] cfg_rows;

  function automatic logic [CEW-1:0] clamp_cols(input logic [7:0] v);
    int c;
    c = int'(v);
    if (c < 1) c = 1;
    if (c > MAX_COLUMNS) c = MAX_COLUMNS;
    return CEW'(c);
  endfunction

  function automatic logic [REW-1:0] clamp_rows(input logic [6:0] v);
    int r;
    r = int'(v);
    if (r < 1) r = 1;
    if (r > MAX_ROWS) r = MAX_ROWS;
    return REW'(r);
  endfunction

  tcce_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign can_emit  = !out_valid_r || out_ready;
  assign accept_en = (state_r != B_CLEAR);

  assign newcol   = CEW'(col_r) + CEW'(1);
  assign wrap     = (newcol >= cols_eff_r);
  assign nrow     = REW'(row_r) + REW'(1);
  assign scr      = (nrow >= rows_eff_r);
  assign step_c   = (rows_eff_r < REW'(4)) ? REW'(1) : (rows_eff_r >> 2);
  assign row_after = scr ? RW'(nrow - step_c) : RW'(nrow);

  // column modulo tab width by reciprocal multiply
  assign prod     = PRW'(newcol) * PRW'(RECIP);
  assign quot     = QMW'(prod[PRW-1:16]);
  assign tab_stop = (quot * QMW'(TAB_WIDTH)) == QMW'(newcol);

  assign n_copy        = rows_eff_r - step_r;
  assign src_row       = REW'(cp_row_r) + step_r;
  assign copy_last_col = (cp_col_r == CW'(MAX_COLUMNS - 1));
  assign copy_last     = copy_last_col && (REW'(cp_row_r) == n_copy - REW'(1));
  assign blank_last    = copy_last_col && (REW'(cp_row_r) == rows_eff_r - REW'(1));

  assign rd_col_w    = 32'(cmd_r.rd_col);
  assign rd_row_w    = 32'(cmd_r.rd_row);
  assign rd_in_range = (rd_col_w < 32'(MAX_COLUMNS)) && (rd_row_w < 32'(MAX_ROWS));

  assign cfg_cols = clamp_cols(cfg_data);
  assign cfg_rows = clamp_rows(cfg_data[6:0]);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_CLEAR:  if (clr_cnt_r == AW'(DEPTH - 1)) state_nxt = B_IDLE;
      B_IDLE:   if (!q_status.empty) state_nxt = B_EXEC;
      B_EXEC: begin
        case (cmd_r.kind)
          CMD_PUT, CMD_TAB: state_nxt = B_EMIT;
          CMD_NL:           state_nxt = scr ? B_EMIT : B_IDLE;
          CMD_READ:         state_nxt = B_RDWAIT;
          default:          state_nxt = B_IDLE;
        endcase
      end
      B_RDWAIT: state_nxt = B_EMIT;
      B_EMIT: begin
        if (can_emit) begin
          if (sc_pend_r)        state_nxt = B_EMIT;
          else if (copy_pend_r) state_nxt = (n_copy == '0) ? B_SBLANK : B_SCOPY;
          else if (tab_more_r)  state_nxt = B_EXEC;
          else                  state_nxt = B_IDLE;
        end
      end
      B_SCOPY:  if (copy_last) state_nxt = B_SDRAIN;
      B_SDRAIN: state_nxt = B_SBLANK;
      B_SBLANK: if (blank_last) state_nxt = B_IDLE;
      default:  state_nxt = B_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cmd_nxt       = cmd_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    cols_eff_nxt  = cols_eff_r;
    rows_eff_nxt  = rows_eff_r;
    step_nxt      = step_r;
    cp_row_nxt    = cp_row_r;
    cp_col_nxt    = cp_col_r;
    wr_pend_nxt   = 1'b0;
    wr_addr_nxt   = wr_addr_r;
    clr_cnt_nxt   = clr_cnt_r;
    oob_nxt       = oob_r;
    sc_pend_nxt   = sc_pend_r;
    copy_pend_nxt = copy_pend_r;
    tab_more_nxt  = tab_more_r;
    ev_kind_nxt   = ev_kind_r;
    ev_col_nxt    = ev_col_r;
    ev_row_nxt    = ev_row_r;
    ev_glyph_nxt  = ev_glyph_r;
    ev_scr_nxt    = ev_scr_r;
    ev_ccol_nxt   = ev_ccol_r;
    ev_crow_nxt   = ev_crow_r;
    ev_last_nxt   = ev_last_r;
    pop           = 1'b0;
    load_out      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = {row_r, col_r};
    ram_wdata     = cmd_r.glyph;
    ram_raddr     = {rd_row_w[RW-1:0], rd_col_w[CW-1:0]};

    case (state_r)
      // sweep the grid to blanks after reset
      B_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = BLANK_GLYPH;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
      end
      B_IDLE: begin
        if (!q_status.empty) begin
          pop     = 1'b1;
          cmd_nxt = head_cmd;
        end
      end
      B_EXEC: begin
        case (cmd_r.kind)
          CMD_PUT, CMD_TAB: begin
            ram_we        = 1'b1;
            ev_kind_nxt   = EV_WRITE;
            ev_col_nxt    = 7'(col_r);
            ev_row_nxt    = 6'(row_r);
            ev_glyph_nxt  = (cmd_r.kind == CMD_TAB) ? BLANK_GLYPH : cmd_r.glyph;
            ram_wdata     = ev_glyph_nxt;
            ev_scr_nxt    = 7'd0;
            step_nxt      = step_c;
            if (wrap) begin
              col_nxt = '0;
              row_nxt = row_after;
            end else begin
              col_nxt = CW'(newcol);
            end
            sc_pend_nxt   = wrap && scr;
            copy_pend_nxt = wrap && scr;
            tab_more_nxt  = (cmd_r.kind == CMD_TAB) && !wrap && !tab_stop;
            ev_last_nxt   = !(wrap && scr) && !tab_more_nxt;
            ev_ccol_nxt   = 7'(col_nxt);
            ev_crow_nxt   = 6'(row_nxt);
          end
          CMD_NL: begin
            col_nxt       = '0;
            row_nxt       = row_after;
            step_nxt      = step_c;
            ev_kind_nxt   = EV_SCROLL;
            ev_col_nxt    = 7'd0;
            ev_row_nxt    = 6'd0;
            ev_glyph_nxt  = 8'd0;
            ev_scr_nxt    = 7'(step_c);
            ev_ccol_nxt   = 7'd0;
            ev_crow_nxt   = 6'(row_after);
            ev_last_nxt   = 1'b1;
            sc_pend_nxt   = 1'b0;
            copy_pend_nxt = scr;
            tab_more_nxt  = 1'b0;
          end
          CMD_CR: col_nxt = '0;
          CMD_BS: if (col_r != '0) col_nxt = col_r - CW'(1);
          CMD_READ: oob_nxt = !rd_in_range;
          default: ;
        endcase
      end
      B_RDWAIT: begin
        ev_kind_nxt  = EV_READ;
        ev_col_nxt   = cmd_r.rd_col;
        ev_row_nxt   = cmd_r.rd_row;
        ev_glyph_nxt = oob_r ? BLANK_GLYPH : ram_rdata;
        ev_scr_nxt   = 7'd0;
        ev_ccol_nxt  = 7'(col_r);
        ev_crow_nxt  = 6'(row_r);
        ev_last_nxt  = 1'b1;
        sc_pend_nxt  = 1'b0;
        copy_pend_nxt = 1'b0;
        tab_more_nxt = 1'b0;
      end
      B_EMIT: begin
        if (can_emit) begin
          load_out = 1'b1;
          if (sc_pend_r) begin
            // scroll event follows the cell write that caused it
            sc_pend_nxt  = 1'b0;
            ev_kind_nxt  = EV_SCROLL;
            ev_col_nxt   = 7'd0;
            ev_row_nxt   = 6'd0;
            ev_glyph_nxt = 8'd0;
            ev_scr_nxt   = 7'(step_r);
            ev_ccol_nxt  = 7'(col_r);
            ev_crow_nxt  = 6'(row_r);
            ev_last_nxt  = 1'b1;
          end else if (copy_pend_r) begin
            copy_pend_nxt = 1'b0;
            cp_col_nxt    = '0;
            cp_row_nxt    = (n_copy == '0) ? RW'(n_copy) : '0;
          end
        end
      end
      // slide rows up: read source, write destination in the next cycle
      B_SCOPY: begin
        ram_raddr   = {src_row[RW-1:0], cp_col_r};
        ram_we      = wr_pend_r;
        ram_waddr   = wr_addr_r;
        ram_wdata   = ram_rdata;
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = {cp_row_r, cp_col_r};
        if (copy_last_col) begin
          cp_col_nxt = '0;
          cp_row_nxt = cp_row_r + RW'(1);
        end else begin
          cp_col_nxt = cp_col_r + CW'(1);
        end
        if (copy_last) cp_row_nxt = RW'(n_copy);
      end
      B_SDRAIN: begin
        ram_we     = wr_pend_r;
        ram_waddr  = wr_addr_r;
        ram_wdata  = ram_rdata;
        cp_col_nxt = '0;
        cp_row_nxt = RW'(n_copy);
      end
      // blank the freed rows
      B_SBLANK: begin
        ram_we    = 1'b1;
        ram_waddr = {cp_row_r, cp_col_r};
        ram_wdata = BLANK_GLYPH;
        if (copy_last_col) begin
          cp_col_nxt = '0;
          cp_row_nxt = cp_row_r + RW'(1);
        end else begin
          cp_col_nxt = cp_col_r + CW'(1);
        end
      end
      default: ;
    endcase

    // register writes clamp the cursor into the new size
    if (cfg_we) begin
      if (cfg_index == REG_COLUMNS) begin
        cols_eff_nxt = cfg_cols;
        if (CEW'(col_nxt) >= cfg_cols) col_nxt = CW'(cfg_cols - CEW'(1));
      end else begin
        rows_eff_nxt = cfg_rows;
        if (REW'(row_nxt) >= cfg_rows) row_nxt = RW'(cfg_rows - REW'(1));
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_cnt_r   <= '0;
      col_r       <= '0;
      row_r       <= '0;
      cols_eff_r  <= clamp_cols(8'd80);
      rows_eff_r  <= clamp_rows(7'd25);
      wr_pend_r   <= 1'b0;
      sc_pend_r   <= 1'b0;
      copy_pend_r <= 1'b0;
      tab_more_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      cols_eff_r  <= cols_eff_nxt;
      rows_eff_r  <= rows_eff_nxt;
      wr_pend_r   <= wr_pend_nxt;
      sc_pend_r   <= sc_pend_nxt;
      copy_pend_r <= copy_pend_nxt;
      tab_more_r  <= tab_more_nxt;
      if (load_out)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    step_r     <= step_nxt;
    cp_row_r   <= cp_row_nxt;
    cp_col_r   <= cp_col_nxt;
    wr_addr_r  <= wr_addr_nxt;
    oob_r      <= oob_nxt;
    ev_kind_r  <= ev_kind_nxt;
    ev_col_r   <= ev_col_nxt;
    ev_row_r   <= ev_row_nxt;
    ev_glyph_r <= ev_glyph_nxt;
    ev_scr_r   <= ev_scr_nxt;
    ev_ccol_r  <= ev_ccol_nxt;
    ev_crow_r  <= ev_crow_nxt;
    ev_last_r  <= ev_last_nxt;
    if (load_out) begin
      out_kind_r  <= ev_kind_r;
      out_col_r   <= ev_col_r;
      out_row_r   <= ev_row_r;
      out_glyph_r <= ev_glyph_r;
      out_scr_r   <= ev_scr_r;
      out_ccol_r  <= ev_ccol_r;
      out_crow_r  <= ev_crow_r;
      out_last_r  <= ev_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_kind    = out_kind_r;
  assign out_cell_column   = out_col_r;
  assign out_cell_row      = out_row_r;
  assign out_glyph_code    = out_glyph_r;
  assign out_scrolled_rows = out_scr_r;
  assign out_cursor_column = out_ccol_r;
  assign out_cursor_row    = out_crow_r;
  assign out_last_event    = out_last_r;
endmodule

// ----- design/text_console_cell_engine_unit.sv -----
// Top level of the text console cell engine.
// Flow: with the executor idle, a printable byte's cell-write result is loaded after
//   the queue pop and execute steps; a read result adds a memory read wait step.
// Requests are queued, so input is taken while the executor is busy until the queue
//   fills; a UTF-8 byte that completes nothing is not queued; a tab writes one space
//   per executor pass; a scroll adds one result, then row copy, drain and blanking.
// Reset: synchronous; the grid is swept to spaces over all MAX_ROWS << $clog2(MAX_COLUMNS) cells
//   (8192 at defaults), during which no request is accepted.
`timescale 1ns / 1ps
module text_console_cell_engine_unit #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 64,
  parameter int TAB_WIDTH   = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_mode,
  input  logic [7:0] in_text_byte,
  input  logic [6:0] in_read_column,
  input  logic [5:0] in_read_row,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_event_kind,
  output logic [6:0] out_cell_column,
  output logic [5:0] out_cell_row,
  output logic [7:0] out_glyph_code,
  output logic [6:0] out_scrolled_rows,
  output logic [6:0] out_cursor_column,
  output logic [5:0] out_cursor_row,
  output logic       out_last_event
);
  import tcce_pkg::*;

  cmd_t          push_cmd, head_cmd;
  queue_status_t q_status;
  logic          push, pop, accept_en;

  tcce_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_text_byte   (in_text_byte),
    .in_read_column (in_read_column),
    .in_read_row    (in_read_row),
    .accept_en      (accept_en),
    .q_status       (q_status),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  tcce_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .status   (q_status)
  );

  tcce_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .TAB_WIDTH   (TAB_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .head_cmd          (head_cmd),
    .q_status          (q_status),
    .pop               (pop),
    .accept_en         (accept_en),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_kind    (out_event_kind),
    .out_cell_column   (out_cell_column),
    .out_cell_row      (out_cell_row),
    .out_glyph_code    (out_glyph_code),
    .out_scrolled_rows (out_scrolled_rows),
    .out_cursor_column (out_cursor_column),
    .out_cursor_row    (out_cursor_row),
    .out_last_event    (out_last_event)
  );

  // scroll results always move rows and close their request
  a_scroll_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == EV_SCROLL |-> out_scrolled_rows != 7'd0 && out_last_event)
    else $error("scroll result without rows or not last");

  // a read result is the only result of its request
  a_read_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == EV_READ |-> out_last_event)
    else $error("read result not marked last");

  // no pop from an empty queue and no push into a full one
  a_queue_safe: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && q_status.empty) && !(push && q_status.full))
    else $error("queue overflow or underflow");
endmodule

// ----- test/text_console_cell_engine_unit_test.sv -----
// Self-checking testbench for the text console cell engine: directed table, then random traffic over several sizes.
`timescale 1ns / 1ps
module text_console_cell_engine_unit_test;
  import tcce_pkg::*;

  localparam int GRID_COLS = 128;
  localparam int GRID_ROWS = 64;
  localparam int TAB_STOP = 8;
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ = 1'b1;
  // Worst scroll at full size plus the final drain
  localparam int SETTLE_CYCLES = 9000;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_ITEMS = 160;

  typedef struct packed {
    logic       mode;
    logic [7:0] text;
    logic [6:0] rcol;
    logic [5:0] rrow;
  } request_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] col;
    logic [5:0] row;
    logic [7:0] glyph;
    logic [6:0] scrolled;
    logic [6:0] cur_col;
    logic [5:0] cur_row;
    logic       last;
  } cell_event_t;

  typedef struct {
    request_t   req;
    bit         typed;
    logic [1:0] kind;
    logic [7:0] glyph;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_COLUMNS;
  logic [7:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = MODE_WRITE;
  logic [7:0] in_text_byte = '0;
  logic [6:0] in_read_column = '0;
  logic [5:0] in_read_row = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_event_kind;
  logic [6:0] out_cell_column;
  logic [5:0] out_cell_row;
  logic [7:0] out_glyph_code;
  logic [6:0] out_scrolled_rows;
  logic [6:0] out_cursor_column;
  logic [5:0] out_cursor_row;
  logic out_last_event;

  text_console_cell_engine_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_text_byte(in_text_byte), .in_read_column(in_read_column),
    .in_read_row(in_read_row),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_event_kind(out_event_kind), .out_cell_column(out_cell_column),
    .out_cell_row(out_cell_row), .out_glyph_code(out_glyph_code),
    .out_scrolled_rows(out_scrolled_rows), .out_cursor_column(out_cursor_column),
    .out_cursor_row(out_cursor_row), .out_last_event(out_last_event)
  );

  always #5 clk = ~clk;

  // Shadow console state
  logic [7:0] shadow_cells [GRID_ROWS][GRID_COLS];
  int cur_col, cur_row, pend_conts, cols_reg, rows_reg;
  logic [20:0] partial_cp;
  cell_event_t pending_events[$];
  int mismatches = 0;
  int cycle_count = 0;
  bit calm = 1'b0;
  bit hold_off_req = 1'b0;
  table_row_t dir_rows[$];
  request_t burst[$];

  function automatic int view_cols();
    return (cols_reg < 1) ? 1 : (cols_reg > GRID_COLS) ? GRID_COLS : cols_reg;
  endfunction

  function automatic int view_rows();
    return (rows_reg < 1) ? 1 : (rows_reg > GRID_ROWS) ? GRID_ROWS : rows_reg;
  endfunction

  function automatic void clamp_cursor();
    if (cur_col >= view_cols()) cur_col = view_cols() - 1;
    if (cur_row >= view_rows()) cur_row = view_rows() - 1;
  endfunction

  function automatic void push_event(logic [1:0] kind, int col, int row, logic [7:0] glyph,
                                     int scrolled);
    cell_event_t ev;
    ev.kind = kind;
    ev.col = col[6:0];
    ev.row = row[5:0];
    ev.glyph = glyph;
    ev.scrolled = scrolled[6:0];
    ev.cur_col = cur_col[6:0];
    ev.cur_row = cur_row[5:0];
    ev.last = 1'b0;
    pending_events.push_back(ev);
  endfunction

  // Advance a line; jump-scroll by a quarter of the rows (one row below four) when past the bottom
  function automatic int advance_line();
    int nrows, step;
    nrows = view_rows();
    cur_col = 0;
    cur_row++;
    if (cur_row < nrows) return 0;
    step = (nrows >= 4) ? nrows / 4 : 1;
    for (int r = 0; r < nrows - step; r++) shadow_cells[r] = shadow_cells[r + step];
    for (int r = nrows - step; r < nrows; r++)
      for (int c = 0; c < GRID_COLS; c++) shadow_cells[r][c] = BLANK_GLYPH;
    cur_row -= step;
    return step;
  endfunction

  function automatic void store_cell(logic [7:0] g);
    int col, row, scr;
    col = cur_col;
    row = cur_row;
    scr = 0;
    shadow_cells[row][col] = g;
    cur_col++;
    if (cur_col >= view_cols()) scr = advance_line();
    push_event(EV_WRITE, col, row, g, 0);
    if (scr != 0) push_event(EV_SCROLL, 0, 0, 8'h00, scr);
  endfunction

  // Expected events for one accepted request
  function automatic void predict_console(request_t req);
    int n_prior;
    logic [7:0] c;
    n_prior = pending_events.size();
    c = req.text;
    clamp_cursor();
    if (req.mode == MODE_READ) begin
      push_event(EV_READ, req.rcol, req.rrow, shadow_cells[req.rrow][req.rcol], 0);
    end else if (c >= LEAD2_MIN) begin
      if (c >= LEAD4_MIN) begin
        pend_conts = 3;
        partial_cp = {18'd0, c[2:0]};
      end else if (c >= LEAD3_MIN) begin
        pend_conts = 2;
        partial_cp = {17'd0, c[3:0]};
      end else begin
        pend_conts = 1;
        partial_cp = {16'd0, c[4:0]};
      end
    end else if (c >= CONT_MIN) begin
      if (pend_conts != 0) begin
        partial_cp = {partial_cp[14:0], c[5:0]};
        pend_conts--;
        if (pend_conts == 0)
          store_cell((partial_cp == CP_EN_DASH || partial_cp == CP_EM_DASH ||
                      partial_cp == CP_BAR) ? DASH_GLYPH : HYPHEN_GLYPH);
      end
    end else if (c == BYTE_LF) begin
      int scr;
      scr = advance_line();
      if (scr != 0) push_event(EV_SCROLL, 0, 0, 8'h00, scr);
    end else if (c == BYTE_CR) begin
      cur_col = 0;
    end else if (c == BYTE_BS) begin
      if (cur_col != 0) cur_col--;
    end else if (c == BYTE_TAB) begin
      do store_cell(BLANK_GLYPH); while ((cur_col % TAB_STOP) != 0);
    end else begin
      store_cell(c);
    end
    if (pending_events.size() > n_prior) pending_events[$].last = 1'b1;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
    mismatches++;
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      cell_event_t ev;
      if (pending_events.size() == 0) begin
        report_mismatch("unexpected result kind", out_event_kind, 0);
      end else begin
        ev = pending_events.pop_front();
        if (out_event_kind !== ev.kind) report_mismatch("event_kind", out_event_kind, ev.kind);
        if (out_cell_column !== ev.col) report_mismatch("cell_column", out_cell_column, ev.col);
        if (out_cell_row !== ev.row) report_mismatch("cell_row", out_cell_row, ev.row);
        if (out_glyph_code !== ev.glyph) report_mismatch("glyph_code", out_glyph_code, ev.glyph);
        if (out_scrolled_rows !== ev.scrolled)
          report_mismatch("scrolled_rows", out_scrolled_rows, ev.scrolled);
        if (out_cursor_column !== ev.cur_col)
          report_mismatch("cursor_column", out_cursor_column, ev.cur_col);
        if (out_cursor_row !== ev.cur_row)
          report_mismatch("cursor_row", out_cursor_row, ev.cur_row);
        if (out_last_event !== ev.last)
          report_mismatch("last_event", out_last_event, ev.last);
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request
  always @(posedge clk) begin
    int stall;
    int hold_cnt;
    bit held;
    if (hold_off_req && !held) begin
      held = 1'b1;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if (stall > 0) begin
      stall--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall = $urandom_range(1, 15) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offer one request and wait for it to be taken
  task automatic send_request(request_t req);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= req.mode;
    in_text_byte <= req.text;
    in_read_column <= req.rcol;
    in_read_row <= req.rrow;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_console(req);
  endtask

  task automatic drain_idle();
    in_valid <= 1'b0;
    wait (pending_events.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write while the block is idle
  task automatic write_sizes(logic [7:0] cols, logic [6:0] rows);
    drain_idle();
    cfg_we <= 1'b1;
    cfg_index <= REG_COLUMNS;
    cfg_data <= cols;
    @(posedge clk);
    cols_reg = cols;
    clamp_cursor();
    cfg_index <= REG_ROWS;
    cfg_data <= {1'b0, rows};
    @(posedge clk);
    rows_reg = rows;
    clamp_cursor();
    cfg_we <= 1'b0;
  endtask

  function automatic request_t text_req(logic [7:0] b);
    request_t r;
    r.mode = MODE_WRITE;
    r.text = b;
    r.rcol = 7'($urandom);
    r.rrow = 6'($urandom);
    return r;
  endfunction

  function automatic request_t read_req(logic [6:0] col, logic [5:0] row);
    request_t r;
    r.mode = MODE_READ;
    r.text = 8'($urandom);
    r.rcol = col;
    r.rrow = row;
    return r;
  endfunction

  function automatic void add_row(request_t req, bit typed = 1'b0,
                                  logic [1:0] kind = EV_WRITE, logic [7:0] glyph = 8'h00);
    table_row_t t;
    t.req = req;
    t.typed = typed;
    t.kind = kind;
    t.glyph = glyph;
    dir_rows.push_back(t);
  endfunction

  // One random burst of console traffic, mostly well formed
  function automatic void make_burst();
    int pick;
    int nconts;
    burst.delete();
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      burst.push_back(text_req(8'($urandom_range(8'h20, 8'h7E))));
    end else if (pick < 48) begin
      burst.push_back(text_req(BYTE_LF));
    end else if (pick < 51) begin
      burst.push_back(text_req(BYTE_CR));
    end else if (pick < 54) begin
      burst.push_back(text_req(BYTE_BS));
    end else if (pick < 58) begin
      burst.push_back(text_req(BYTE_TAB));
    end else if (pick < 72) begin
      burst.push_back(read_req(7'($urandom), 6'($urandom)));
    end else if (pick < 80) begin
      burst.push_back(text_req(8'hE2));
      burst.push_back(text_req(8'h80));
      burst.push_back(text_req(8'($urandom_range(8'h93, 8'h95))));
    end else if (pick < 90) begin
      nconts = $urandom_range(1, 3);
      burst.push_back(text_req(nconts == 1 ? 8'($urandom_range(8'hC0, 8'hDF)) :
                               nconts == 2 ? 8'($urandom_range(8'hE0, 8'hEF)) :
                                             8'($urandom_range(8'hF0, 8'hFF))));
      // Sometimes cut short to leave the sequence open
      if ($urandom_range(0, 4) == 0) nconts = $urandom_range(0, nconts - 1);
      repeat (nconts) burst.push_back(text_req(8'($urandom_range(8'h80, 8'hBF))));
    end else begin
      burst.push_back(text_req(8'($urandom)));
    end
  endfunction

  task automatic random_phase(int items);
    int sent;
    sent = 0;
    while (sent < items) begin
      make_burst();
      foreach (burst[i]) send_request(burst[i]);
      sent += burst.size();
    end
  endtask

  initial begin
    for (int r = 0; r < GRID_ROWS; r++)
      for (int c = 0; c < GRID_COLS; c++) shadow_cells[r][c] = BLANK_GLYPH;
    cur_col = 0;
    cur_row = 0;
    pend_conts = 0;
    partial_cp = '0;
    cols_reg = 80;
    rows_reg = 25;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table; typed rows are obvious at a glance
    add_row(read_req(7'd0, 6'd0), 1'b1, EV_READ, BLANK_GLYPH);
    add_row(text_req(8'h41), 1'b1, EV_WRITE, 8'h41);
    add_row(read_req(7'd127, 6'd63), 1'b1, EV_READ, BLANK_GLYPH);
    add_row(text_req(8'hE2));
    add_row(text_req(8'h80));
    add_row(text_req(8'h93), 1'b1, EV_WRITE, DASH_GLYPH);
    add_row(text_req(8'hE2));
    add_row(text_req(8'h80));
    add_row(text_req(8'h95), 1'b1, EV_WRITE, DASH_GLYPH);
    add_row(text_req(8'hC3));
    add_row(text_req(8'hA9), 1'b1, EV_WRITE, HYPHEN_GLYPH);
    add_row(text_req(8'hBF));
    add_row(text_req(8'hFF));
    add_row(text_req(8'hE2));
    add_row(text_req(8'h5A), 1'b1, EV_WRITE, 8'h5A);
    add_row(text_req(8'h80));
    add_row(text_req(8'h94), 1'b1, EV_WRITE, DASH_GLYPH);
    add_row(text_req(BYTE_TAB));
    add_row(text_req(BYTE_BS));
    add_row(text_req(BYTE_CR));
    add_row(text_req(8'h00), 1'b1, EV_WRITE, 8'h00);
    add_row(text_req(8'h7F), 1'b1, EV_WRITE, 8'h7F);
    add_row(text_req(BYTE_LF));
    add_row(read_req(7'd1, 6'd0));
    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].req);
      if (dir_rows[i].typed) begin
        if (pending_events.size() == 0)
          report_mismatch("table row without result", i, 0);
        else if (pending_events[$].kind !== dir_rows[i].kind ||
                 pending_events[$].glyph !== dir_rows[i].glyph)
          report_mismatch("table row glyph", pending_events[$].glyph, dir_rows[i].glyph);
      end
    end

    // Long receiver hold-off while text keeps coming
    hold_off_req = 1'b1;
    random_phase(20);

    // Size settings, extremes included
    write_sizes(8'd0, 7'd0);
    random_phase(15);
    write_sizes(8'd255, 7'd127);
    random_phase(20);
    write_sizes(8'd9, 7'd4);
    random_phase(20);
    write_sizes(8'd1, 7'd3);
    random_phase(10);
    write_sizes(8'd128, 7'd64);
    random_phase(15);
    write_sizes(8'd20, 7'd5);
    random_phase(10);
    calm = 1'b1;
    random_phase(RANDOM_ITEMS / 8);

    in_valid <= 1'b0;
    wait (pending_events.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
